>>> hdl/pfcs_pkg.sv
// Shared constants and types for the parallel flash command sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pfcs_pkg;

    // Widths and defaults
    localparam int unsigned FLASH_ADDR_BITS_DEF = 19;
    localparam int unsigned RUN_MAX             = 7;   // longest result run of one transfer
    localparam int unsigned RUN_CNT_W           = 3;

    // Request codes
    localparam logic [1:0] REQ_READ_ID = 2'd0;
    localparam logic [1:0] REQ_ERASE   = 2'd1;
    localparam logic [1:0] REQ_PROGRAM = 2'd2;
    localparam logic [1:0] REQ_DATA    = 2'd3;

    // Result operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WAIT  = 2'd2;
    localparam logic [1:0] OP_DONE  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ERASE_POLL_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_PROGRAM_POLL_LIMIT = 2'd1;
    localparam logic [1:0] CFG_ID_SETTLE_TIME     = 2'd2;

    localparam logic [15:0] ERASE_POLL_LIMIT_RST   = 16'd43000;
    localparam logic [15:0] PROGRAM_POLL_LIMIT_RST = 16'd35;
    localparam logic [15:0] ID_SETTLE_TIME_RST     = 16'd20;

    // Bus addresses and command bytes
    localparam logic [15:0] ADDR_UNLOCK_A = 16'h5555;
    localparam logic [15:0] ADDR_UNLOCK_B = 16'h2AAA;
    localparam logic [15:0] ADDR_ID_MANU  = 16'h0000;
    localparam logic [15:0] ADDR_ID_DEV   = 16'h0001;

    localparam logic [7:0] CMD_UNLOCK_A = 8'hAA;
    localparam logic [7:0] CMD_UNLOCK_B = 8'h55;
    localparam logic [7:0] CMD_ID_ENTRY = 8'h90;
    localparam logic [7:0] CMD_ERASE    = 8'h80;
    localparam logic [7:0] CMD_SECTOR   = 8'h30;
    localparam logic [7:0] CMD_PROGRAM  = 8'hA0;
    localparam logic [7:0] CMD_RESET    = 8'hF0;
    localparam logic [7:0] ERASED_BYTE  = 8'hFF;

    localparam logic [7:0] MANU_KNOWN  = 8'hBF;
    localparam logic [7:0] DEV_256K    = 8'hD6;
    localparam logic [7:0] DEV_512K    = 8'hD7;

    localparam logic [1:0] SIZE_UNSUPPORTED = 2'd0;
    localparam logic [1:0] SIZE_256K        = 2'd1;
    localparam logic [1:0] SIZE_512K        = 2'd2;

    // Per-run fields shared by all results of one transfer
    typedef struct packed {
        logic [RUN_CNT_W-1:0] len;
        logic [15:0]          wait_time;
        logic                 success;
        logic [7:0]           manufacturer;
        logic [7:0]           device_id;
        logic [1:0]           chip_size_code;
    } t_run_ctl;

endpackage

`default_nettype wire

>>> hdl/pfcs_seq.sv
// Sequencer state and the single-step decode of one input transfer into a result run.
// Depends on pfcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfcs_seq #(
    parameter int unsigned FLASH_ADDR_BITS = pfcs_pkg::FLASH_ADDR_BITS_DEF
) (
    input  wire logic                                             i_clk,
    input  wire logic                                             i_rst_n,
    input  wire logic                                             i_step,
    input  wire logic [1:0]                                       i_req_type,
    input  wire logic [FLASH_ADDR_BITS-1:0]                       i_address,
    input  wire logic [7:0]                                       i_write_data,
    input  wire logic [7:0]                                       i_read_data,
    input  wire logic [15:0]                                      i_erase_poll_limit,
    input  wire logic [15:0]                                      i_program_poll_limit,
    input  wire logic [15:0]                                      i_id_settle_time,
    output logic [pfcs_pkg::RUN_MAX-1:0][1:0]                     o_run_op,
    output logic [pfcs_pkg::RUN_MAX-1:0][FLASH_ADDR_BITS-1:0]     o_run_addr,
    output logic [pfcs_pkg::RUN_MAX-1:0][7:0]                     o_run_data,
    output pfcs_pkg::t_run_ctl                                    o_run_ctl
);
    import pfcs_pkg::*;

    localparam int unsigned AW = FLASH_ADDR_BITS;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_RID_N0     = 3'd1;
    localparam logic [2:0] PH_RID_N1     = 3'd2;
    localparam logic [2:0] PH_RID_I0     = 3'd3;
    localparam logic [2:0] PH_RID_I1     = 3'd4;
    localparam logic [2:0] PH_ERASE_POLL = 3'd5;
    localparam logic [2:0] PH_PROG_CHECK = 3'd6;
    localparam logic [2:0] PH_PROG_POLL  = 3'd7;

    localparam logic [AW-1:0] A_UNLK_A = AW'(ADDR_UNLOCK_A);
    localparam logic [AW-1:0] A_UNLK_B = AW'(ADDR_UNLOCK_B);
    localparam logic [AW-1:0] A_MANU   = AW'(ADDR_ID_MANU);
    localparam logic [AW-1:0] A_DEV    = AW'(ADDR_ID_DEV);

    logic [2:0]    r_phase,    n_phase;
    logic [AW-1:0] r_tgt_addr, n_tgt_addr;
    logic [7:0]    r_tgt_data, n_tgt_data;
    logic [15:0]   r_poll,     n_poll;
    logic [7:0]    r_nb0,      n_nb0;
    logic [7:0]    r_nb1,      n_nb1;
    logic [7:0]    r_id0,      n_id0;

    logic          id_ok;
    logic          poll_out;

    assign id_ok    = (r_id0 != r_nb0) || (i_read_data != r_nb1);
    assign poll_out = (r_poll <= 16'd1);

    always_comb begin
        n_phase    = r_phase;
        n_tgt_addr = r_tgt_addr;
        n_tgt_data = r_tgt_data;
        n_poll     = r_poll;
        n_nb0      = r_nb0;
        n_nb1      = r_nb1;
        n_id0      = r_id0;
        o_run_op   = '0;
        o_run_addr = '0;
        o_run_data = '0;
        o_run_ctl  = '0;
        o_run_ctl.wait_time = i_id_settle_time;

        if (i_req_type != REQ_DATA) begin
            // requests are dropped unless idle
            if (r_phase == PH_IDLE) begin
                case (i_req_type)
                    REQ_READ_ID: begin
                        o_run_op[0]   = OP_READ;
                        o_run_addr[0] = A_MANU;
                        o_run_ctl.len = 3'd1;
                        n_phase       = PH_RID_N0;
                    end
                    REQ_ERASE: begin
                        o_run_op   = '0;
                        o_run_addr[0] = A_UNLK_A;  o_run_data[0] = CMD_UNLOCK_A;
                        o_run_addr[1] = A_UNLK_B;  o_run_data[1] = CMD_UNLOCK_B;
                        o_run_addr[2] = A_UNLK_A;  o_run_data[2] = CMD_ERASE;
                        o_run_addr[3] = A_UNLK_A;  o_run_data[3] = CMD_UNLOCK_A;
                        o_run_addr[4] = A_UNLK_B;  o_run_data[4] = CMD_UNLOCK_B;
                        o_run_addr[5] = i_address; o_run_data[5] = CMD_SECTOR;
                        o_run_op[6]   = OP_READ;
                        o_run_addr[6] = i_address;
                        o_run_ctl.len = 3'd7;
                        n_tgt_addr    = i_address;
                        n_poll        = i_erase_poll_limit;
                        n_phase       = PH_ERASE_POLL;
                    end
                    REQ_PROGRAM: begin
                        o_run_op[0]   = OP_READ;
                        o_run_addr[0] = i_address;
                        o_run_ctl.len = 3'd1;
                        n_tgt_addr    = i_address;
                        n_tgt_data    = i_write_data;
                        n_phase       = PH_PROG_CHECK;
                    end
                    default: ;
                endcase
            end
        end else begin
            case (r_phase)
                PH_RID_N0: begin
                    n_nb0         = i_read_data;
                    o_run_op[0]   = OP_READ;
                    o_run_addr[0] = A_DEV;
                    o_run_ctl.len = 3'd1;
                    n_phase       = PH_RID_N1;
                end
                PH_RID_N1: begin
                    n_nb1         = i_read_data;
                    o_run_addr[0] = A_UNLK_A;  o_run_data[0] = CMD_UNLOCK_A;
                    o_run_addr[1] = A_UNLK_B;  o_run_data[1] = CMD_UNLOCK_B;
                    o_run_addr[2] = A_UNLK_A;  o_run_data[2] = CMD_ID_ENTRY;
                    o_run_op[3]   = OP_WAIT;
                    o_run_op[4]   = OP_READ;
                    o_run_addr[4] = A_MANU;
                    o_run_ctl.len = 3'd5;
                    n_phase       = PH_RID_I0;
                end
                PH_RID_I0: begin
                    n_id0         = i_read_data;
                    o_run_op[0]   = OP_READ;
                    o_run_addr[0] = A_DEV;
                    o_run_ctl.len = 3'd1;
                    n_phase       = PH_RID_I1;
                end
                PH_RID_I1: begin
                    o_run_addr[0] = A_MANU;  o_run_data[0] = CMD_RESET;
                    o_run_op[1]   = OP_WAIT;
                    o_run_op[2]   = OP_DONE;
                    o_run_ctl.len = 3'd3;
                    o_run_ctl.success = id_ok;
                    if (id_ok) begin
                        o_run_ctl.manufacturer = r_id0;
                        o_run_ctl.device_id    = i_read_data;
                        if (r_id0 == MANU_KNOWN && i_read_data == DEV_256K) begin
                            o_run_ctl.chip_size_code = SIZE_256K;
                        end else if (r_id0 == MANU_KNOWN && i_read_data == DEV_512K) begin
                            o_run_ctl.chip_size_code = SIZE_512K;
                        end else begin
                            o_run_ctl.chip_size_code = SIZE_UNSUPPORTED;
                        end
                    end
                    n_phase = PH_IDLE;
                end
                PH_ERASE_POLL, PH_PROG_POLL: begin
                    o_run_ctl.len = 3'd1;
                    if ((r_phase == PH_ERASE_POLL && i_read_data == ERASED_BYTE) ||
                        (r_phase == PH_PROG_POLL && i_read_data == r_tgt_data)) begin
                        o_run_op[0]       = OP_DONE;
                        o_run_ctl.success = 1'b1;
                        n_phase           = PH_IDLE;
                    end else if (poll_out) begin
                        o_run_op[0] = OP_DONE;
                        n_poll      = '0;
                        n_phase     = PH_IDLE;
                    end else begin
                        o_run_op[0]   = OP_READ;
                        o_run_addr[0] = r_tgt_addr;
                        n_poll        = r_poll - 16'd1;
                    end
                end
                PH_PROG_CHECK: begin
                    if ((~i_read_data & r_tgt_data) != 8'd0) begin
                        // would need a 0 -> 1 transition
                        o_run_op[0]   = OP_DONE;
                        o_run_ctl.len = 3'd1;
                        n_phase       = PH_IDLE;
                    end else begin
                        o_run_addr[0] = A_UNLK_A;   o_run_data[0] = CMD_UNLOCK_A;
                        o_run_addr[1] = A_UNLK_B;   o_run_data[1] = CMD_UNLOCK_B;
                        o_run_addr[2] = A_UNLK_A;   o_run_data[2] = CMD_PROGRAM;
                        o_run_addr[3] = r_tgt_addr; o_run_data[3] = r_tgt_data;
                        o_run_op[4]   = OP_READ;
                        o_run_addr[4] = r_tgt_addr;
                        o_run_ctl.len = 3'd5;
                        n_poll        = i_program_poll_limit;
                        n_phase       = PH_PROG_POLL;
                    end
                end
                default: ;  // stray read data while idle
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tgt_addr <= '0;
            r_tgt_data <= '0;
            r_poll     <= '0;
            r_nb0      <= '0;
            r_nb1      <= '0;
            r_id0      <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_tgt_addr <= n_tgt_addr;
            r_tgt_data <= n_tgt_data;
            r_poll     <= n_poll;
            r_nb0      <= n_nb0;
            r_nb1      <= n_nb1;
            r_id0      <= n_id0;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pfcs_obuf.sv
// Result run buffer: holds one run of up to RUN_MAX results and shifts them out.
// Depends on pfcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfcs_obuf #(
    parameter int unsigned FLASH_ADDR_BITS = pfcs_pkg::FLASH_ADDR_BITS_DEF
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_load,
    input  wire logic [pfcs_pkg::RUN_MAX-1:0][1:0]            i_run_op,
    input  wire logic [pfcs_pkg::RUN_MAX-1:0][FLASH_ADDR_BITS-1:0] i_run_addr,
    input  wire logic [pfcs_pkg::RUN_MAX-1:0][7:0]            i_run_data,
    input  pfcs_pkg::t_run_ctl                                i_run_ctl,
    input  wire logic                                         i_out_ready,
    output logic                                              o_free,
    output logic                                              o_out_valid,
    output logic [1:0]                                        o_op,
    output logic [FLASH_ADDR_BITS-1:0]                        o_bus_address,
    output logic [7:0]                                        o_bus_data,
    output logic [15:0]                                       o_wait_time,
    output logic                                              o_success,
    output logic [7:0]                                        o_manufacturer,
    output logic [7:0]                                        o_device_id,
    output logic [1:0]                                        o_chip_size_code,
    output logic                                              o_last_of_run
);
    import pfcs_pkg::*;

    logic [RUN_CNT_W-1:0]                         r_cnt;
    logic [RUN_MAX-1:0][1:0]                      r_op;
    logic [RUN_MAX-1:0][FLASH_ADDR_BITS-1:0]      r_addr;
    logic [RUN_MAX-1:0][7:0]                      r_data;
    t_run_ctl                                     r_ctl;
    logic                                         take;
    logic                                         is_done;

    assign take    = (r_cnt != '0) && i_out_ready;
    assign o_free  = (r_cnt == '0) || ((r_cnt == RUN_CNT_W'(1)) && i_out_ready);
    assign is_done = (r_op[0] == OP_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_run_ctl.len;
        end else if (take) begin
            r_cnt <= r_cnt - RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_op   <= i_run_op;
            r_addr <= i_run_addr;
            r_data <= i_run_data;
            r_ctl  <= i_run_ctl;
        end else if (take) begin
            for (int i = 0; i < RUN_MAX - 1; i++) begin
                r_op[i]   <= r_op[i+1];
                r_addr[i] <= r_addr[i+1];
                r_data[i] <= r_data[i+1];
            end
        end
    end

    assign o_out_valid      = (r_cnt != '0);
    assign o_op             = r_op[0];
    assign o_bus_address    = r_addr[0];
    assign o_bus_data       = r_data[0];
    assign o_wait_time      = (r_op[0] == OP_WAIT) ? r_ctl.wait_time : '0;
    assign o_success        = is_done && r_ctl.success;
    assign o_manufacturer   = is_done ? r_ctl.manufacturer : '0;
    assign o_device_id      = is_done ? r_ctl.device_id : '0;
    assign o_chip_size_code = is_done ? r_ctl.chip_size_code : '0;
    assign o_last_of_run    = (r_cnt == RUN_CNT_W'(1));

endmodule

`default_nettype wire

>>> hdl/parallel_flash_command_sequencer.sv
// Top level of the parallel NOR flash command sequencer: input register, config registers,
// sequencer step and result run buffer. Depends on pfcs_pkg, pfcs_seq, pfcs_obuf.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                    Payload
// in        i_in_valid / o_in_ready      req_type, address, write_data, read_data
// out       o_out_valid / i_out_ready    op, bus_address, bus_data, wait_time, success,
//                                        manufacturer, device_id, chip_size_code, last_of_run
// cfg       i_cfg_we (no wait)           i_cfg_index, i_cfg_wdata
//
// An input transfer lands in the input register, then is decoded into a run of 0..7 results
// that loads the run buffer. Results leave one per cycle while i_out_ready is high, the first
// in the cycle after decode. A transfer with n results holds the run buffer until all n are
// taken; one with no results (busy request, stray data) only clears the input register.
// Input is taken in every cycle the input register is empty or being drained into a free
// run buffer, so a result stall backs up through to o_in_ready. Reset is synchronous.

module parallel_flash_command_sequencer #(
    parameter int unsigned FLASH_ADDR_BITS = pfcs_pkg::FLASH_ADDR_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [15:0]                i_cfg_wdata,
    // input channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_req_type,
    input  wire logic [FLASH_ADDR_BITS-1:0] i_address,
    input  wire logic [7:0]                 i_write_data,
    input  wire logic [7:0]                 i_read_data,
    // result channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [1:0]                      o_op,
    output logic [FLASH_ADDR_BITS-1:0]      o_bus_address,
    output logic [7:0]                      o_bus_data,
    output logic [15:0]                     o_wait_time,
    output logic                            o_success,
    output logic [7:0]                      o_manufacturer,
    output logic [7:0]                      o_device_id,
    output logic [1:0]                      o_chip_size_code,
    output logic                            o_last_of_run
);
    import pfcs_pkg::*;

    // config registers
    logic [15:0] r_erase_poll_limit;
    logic [15:0] r_program_poll_limit;
    logic [15:0] r_id_settle_time;

    // input register
    logic                       r_in_valid;
    logic [1:0]                 r_req_type;
    logic [FLASH_ADDR_BITS-1:0] r_address;
    logic [7:0]                 r_write_data;
    logic [7:0]                 r_read_data;

    logic                                   buf_free;
    logic                                   step;
    logic [RUN_MAX-1:0][1:0]                run_op;
    logic [RUN_MAX-1:0][FLASH_ADDR_BITS-1:0] run_addr;
    logic [RUN_MAX-1:0][7:0]                run_data;
    t_run_ctl                               run_ctl;

    // decode the held transfer once the run buffer can take its results
    assign step       = r_in_valid && buf_free;
    assign o_in_ready = !r_in_valid || buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase_poll_limit   <= ERASE_POLL_LIMIT_RST;
            r_program_poll_limit <= PROGRAM_POLL_LIMIT_RST;
            r_id_settle_time     <= ID_SETTLE_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ERASE_POLL_LIMIT:   r_erase_poll_limit   <= i_cfg_wdata;
                CFG_PROGRAM_POLL_LIMIT: r_program_poll_limit <= i_cfg_wdata;
                CFG_ID_SETTLE_TIME:     r_id_settle_time     <= i_cfg_wdata;
                default: ;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req_type   <= i_req_type;
            r_address    <= i_address;
            r_write_data <= i_write_data;
            r_read_data  <= i_read_data;
        end
    end

    pfcs_seq #(
        .FLASH_ADDR_BITS (FLASH_ADDR_BITS)
    ) u_seq (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_step               (step),
        .i_req_type           (r_req_type),
        .i_address            (r_address),
        .i_write_data         (r_write_data),
        .i_read_data          (r_read_data),
        .i_erase_poll_limit   (r_erase_poll_limit),
        .i_program_poll_limit (r_program_poll_limit),
        .i_id_settle_time     (r_id_settle_time),
        .o_run_op             (run_op),
        .o_run_addr           (run_addr),
        .o_run_data           (run_data),
        .o_run_ctl            (run_ctl)
    );

    // empty runs never load the buffer
    pfcs_obuf #(
        .FLASH_ADDR_BITS (FLASH_ADDR_BITS)
    ) u_obuf (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (step && (run_ctl.len != '0)),
        .i_run_op         (run_op),
        .i_run_addr       (run_addr),
        .i_run_data       (run_data),
        .i_run_ctl        (run_ctl),
        .i_out_ready      (i_out_ready),
        .o_free           (buf_free),
        .o_out_valid      (o_out_valid),
        .o_op             (o_op),
        .o_bus_address    (o_bus_address),
        .o_bus_data       (o_bus_data),
        .o_wait_time      (o_wait_time),
        .o_success        (o_success),
        .o_manufacturer   (o_manufacturer),
        .o_device_id      (o_device_id),
        .o_chip_size_code (o_chip_size_code),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

`default_nettype wire

>>> hdl/pfcs_checker.sv
// Port-level assertions for the flash command sequencer, bound to the top level.
// Depends on pfcs_pkg and parallel_flash_command_sequencer.
`timescale 1ns / 1ps
`default_nettype none

module pfcs_checker #(
    parameter int unsigned FLASH_ADDR_BITS = pfcs_pkg::FLASH_ADDR_BITS_DEF
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [1:0]                 o_op,
    input wire logic [FLASH_ADDR_BITS-1:0] o_bus_address,
    input wire logic [7:0]                 o_bus_data,
    input wire logic                       o_success,
    input wire logic [7:0]                 o_manufacturer,
    input wire logic [7:0]                 o_device_id,
    input wire logic [1:0]                 o_chip_size_code,
    input wire logic                       o_last_of_run
);
    import pfcs_pkg::*;

    // reset empties the result side
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_op)
            && $stable(o_bus_address) && $stable(o_bus_data) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // done always closes its run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_op == OP_DONE |-> o_last_of_run)
        else $error("done result not last of run");

    // ID results and success only ride on done, and only on success
    a_id_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_success |-> o_manufacturer == '0 && o_device_id == '0
            && o_chip_size_code == '0)
        else $error("ID fields set without success");

    // a wait carries no bus traffic and never closes a run
    a_wait_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_op == OP_WAIT |-> o_bus_address == '0 && o_bus_data == '0
            && !o_last_of_run)
        else $error("wait result with bus fields or closing a run");

endmodule

bind parallel_flash_command_sequencer pfcs_checker #(
    .FLASH_ADDR_BITS (FLASH_ADDR_BITS)
) u_pfcs_checker (.*);

`default_nettype wire
